// ===== design/arwr_pkg.sv =====
`default_nettype none
package arwr_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

    localparam logic [14:0] HALF_WINDOW_RESET = 15'd1024;
    localparam logic [19:0] MSG_LEN_MAX = 20'hFFFFF;

    typedef enum logic [1:0] {
        KIND_PACKET = 2'd0,
        KIND_SYNC   = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SCAN,
        ST_EMIT
    } t_state;

    // one held packet; ack zero marks an empty slot
    typedef struct packed {
        logic [15:0] ack;
        logic [15:0] frags;
        logic [15:0] opcode;
        logic [15:0] length;
        logic [15:0] handle;
    } t_slot;

    localparam t_slot SLOT_EMPTY = '0;

endpackage
`default_nettype wire

// ===== design/ack_reorder_window_reassembly.sv =====
// Receive-side reorder window of a reliable datagram link. One transaction on
// the input channel is a packet (kind 0), a sync (kind 1, sets the expected
// ack) or a keep-alive query (kind 2, answers expected-1). Kind 3 is ignored.
// An in-order unfragmented packet with nothing held is delivered directly;
// other packets that fit the window are parked in a row of 32 slot cells at
// their offset from the window base, then the row is drained in order. A
// parked packet takes an evaluation step, a scan during which the cell row
// rotates one full turn past the front cell, and a drain in which one piece
// is delivered per cycle while the output is not stalled, as the row shifts
// out. One transaction is handled at a time.
// compare_half_window lives at APB byte address 0.
`default_nettype none
module ack_reorder_window_reassembly
    import arwr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    // APB configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_kind,
    input  wire  [15:0] i_ack_request,
    input  wire  [15:0] i_frag_count,
    input  wire  [15:0] i_opcode,
    input  wire  [15:0] i_payload_length,
    input  wire  [15:0] i_payload_handle,
    // result channel
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic        o_event_res,
    output logic [15:0] o_piece_handle,
    output logic [15:0] o_piece_opcode,
    output logic [15:0] o_piece_length,
    output logic        o_message_end,
    output logic [19:0] o_message_length,
    output logic [15:0] o_ack_value,
    output logic        o_last
);

    // ---------------- configuration ----------------
    logic [14:0] r_half;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_WINDOW_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_half <= pwdata[14:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {17'd0, r_half};

    // ---------------- control state ----------------
    t_state             r_state, n_state;
    logic [15:0]        r_next_exp, n_next_exp;
    logic [15:0]        r_base, n_base;
    logic [15:0]        r_last_ack, n_last_ack;
    logic [CNT_W-1:0]   r_held, n_held;
    logic [IDX_W-1:0]   r_scan_idx, n_scan_idx;
    logic               r_stopped, n_stopped;
    logic [CNT_W-1:0]   r_consumed, n_consumed;
    logic [CNT_W-1:0]   r_frags_seen, n_frags_seen;
    logic [CNT_W-1:0]   r_grp_cnt, n_grp_cnt;
    logic [20:0]        r_grp_sum, n_grp_sum;

    // latched input transaction
    t_kind              r_kind;
    t_slot              r_pkt;

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_ev, n_ev;
    logic [15:0]        r_o_handle, n_o_handle;
    logic [15:0]        r_o_opcode, n_o_opcode;
    logic [15:0]        r_o_length, n_o_length;
    logic               r_o_end, n_o_end;
    logic [19:0]        r_o_mlen, n_o_mlen;
    logic [15:0]        r_o_ack, n_o_ack;
    logic               r_o_last, n_o_last;

    // ---------------- cell row ----------------
    t_slot                    w_slot   [WINDOW_DEPTH];
    t_slot                    w_shin   [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]  w_occ;
    logic                     w_wr_en;
    logic                     w_shift;
    logic                     w_rotate;

    logic [15:0]        w_offset;
    logic [IDX_W-1:0]   w_wr_idx;

    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        // scan rotates the front back to the tail; drain fills the tail empty
        if (g == WINDOW_DEPTH - 1) begin : g_tail
            assign w_shin[g] = w_rotate ? w_slot[0] : SLOT_EMPTY;
        end else begin : g_body
            assign w_shin[g] = w_slot[g+1];
        end
        assign w_occ[g] = (w_slot[g].ack != 16'd0);

        arwr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_wr_en      (w_wr_en && (w_wr_idx == IDX_W'(g))),
            .i_wr_data    (r_pkt),
            .i_shift      (w_shift),
            .i_shift_data (w_shin[g]),
            .o_slot       (w_slot[g])
        );
    end

    // ---------------- input capture ----------------
    assign o_in_ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind <= t_kind'(i_kind);
            r_pkt  <= '{ack: i_ack_request, frags: i_frag_count, opcode: i_opcode,
                        length: i_payload_length, handle: i_payload_handle};
        end
    end

    // ---------------- packet classification ----------------
    logic [16:0] w_g, w_e, w_h, w_e_plus, w_e_minus;
    logic        w_future, w_past, w_direct, w_store, w_out_free;

    assign w_g       = {1'b0, r_pkt.ack};
    assign w_e       = {1'b0, r_next_exp};
    assign w_h       = {2'b0, r_half};
    assign w_e_plus  = w_e + w_h;
    assign w_e_minus = w_e - w_h;
    // past/future test around the expected ack; an ack over half a window below it counts as future
    assign w_future  = ((w_g > w_e) && (w_g < w_e_plus)) ||
                       ((w_e >= w_h) && (w_g < w_e_minus));
    assign w_past    = (w_g != w_e) && !w_future;

    assign w_offset  = r_pkt.ack - r_base;
    assign w_wr_idx  = w_offset[IDX_W-1:0];

    assign w_direct  = (r_kind == KIND_PACKET) && (r_pkt.ack == r_next_exp) &&
                       (r_pkt.frags == 16'd0) && (r_held == '0);
    assign w_store   = (r_kind == KIND_PACKET) && !w_direct && !w_past &&
                       (w_offset < 16'(WINDOW_DEPTH)) && (r_pkt.ack != 16'd0) &&
                       (r_pkt.frags <= 16'(WINDOW_DEPTH)) && !w_occ[w_wr_idx];

    assign w_out_free = !r_out_valid || i_out_ready;

    // ---------------- scan step on the front cell ----------------
    t_slot             w_front;
    logic              w_scan_stop, w_scan_take, w_grp_done;
    logic [CNT_W-1:0]  w_frags_inc;

    assign w_front     = w_slot[0];
    assign w_frags_inc = r_frags_seen + CNT_W'(1);
    // stop at an empty slot, a single inside an open group, or a group too big
    assign w_scan_stop = (w_front.ack == 16'd0) ||
                         ((w_front.frags == 16'd0) && (r_frags_seen != '0)) ||
                         ((w_front.frags != 16'd0) &&
                          (w_front.frags > 16'(r_held)));
    assign w_scan_take = !r_stopped && !w_scan_stop;
    assign w_grp_done  = (w_front.frags == 16'd0) ||
                         (16'(w_frags_inc) == w_front.frags);

    // ---------------- drain piece ----------------
    logic [CNT_W-1:0]  w_grp_inc;
    logic [20:0]       w_sum;
    logic              w_piece_end;

    assign w_grp_inc   = r_grp_cnt + CNT_W'(1);
    assign w_sum       = r_grp_sum + 21'(w_front.length);
    assign w_piece_end = (w_front.frags == 16'd0) || (16'(w_grp_inc) == w_front.frags);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_kind == KIND_QUERY || w_direct) begin
                    if (w_out_free) n_state = ST_IDLE;
                end else if (w_store) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (r_scan_idx == IDX_W'(WINDOW_DEPTH - 1)) begin
                    n_state = (r_consumed != '0 || (w_scan_take && w_grp_done))
                              ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_out_free && r_consumed == CNT_W'(1)) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb begin
        n_next_exp   = r_next_exp;
        n_base       = r_base;
        n_last_ack   = r_last_ack;
        n_held       = r_held;
        n_scan_idx   = r_scan_idx;
        n_stopped    = r_stopped;
        n_consumed   = r_consumed;
        n_frags_seen = r_frags_seen;
        n_grp_cnt    = r_grp_cnt;
        n_grp_sum    = r_grp_sum;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_ev         = r_ev;
        n_o_handle   = r_o_handle;
        n_o_opcode   = r_o_opcode;
        n_o_length   = r_o_length;
        n_o_end      = r_o_end;
        n_o_mlen     = r_o_mlen;
        n_o_ack      = r_o_ack;
        n_o_last     = r_o_last;
        w_wr_en      = 1'b0;
        w_shift      = 1'b0;
        w_rotate     = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                n_scan_idx   = '0;
                n_stopped    = 1'b0;
                n_consumed   = '0;
                n_frags_seen = '0;
                n_grp_cnt    = '0;
                n_grp_sum    = '0;
            end
            ST_EVAL: begin
                if (r_kind == KIND_SYNC) begin
                    n_next_exp = r_pkt.ack;
                    n_last_ack = r_pkt.ack - 16'd1;
                end else if (r_kind == KIND_QUERY) begin
                    if (w_out_free) begin
                        n_last_ack  = r_next_exp - 16'd1;
                        n_out_valid = 1'b1;
                        n_ev        = 1'b1;
                        n_o_handle  = '0;
                        n_o_opcode  = '0;
                        n_o_length  = '0;
                        n_o_end     = 1'b0;
                        n_o_mlen    = '0;
                        n_o_ack     = r_next_exp - 16'd1;
                        n_o_last    = 1'b1;
                    end
                end else if (w_direct) begin
                    if (w_out_free) begin
                        n_next_exp  = r_next_exp + 16'd1;
                        n_base      = r_next_exp + 16'd1;
                        n_out_valid = 1'b1;
                        n_ev        = 1'b0;
                        n_o_handle  = r_pkt.handle;
                        n_o_opcode  = r_pkt.opcode;
                        n_o_length  = r_pkt.length;
                        n_o_end     = 1'b1;
                        n_o_mlen    = {4'd0, r_pkt.length};
                        n_o_ack     = '0;
                        n_o_last    = 1'b1;
                    end
                end else if (w_store) begin
                    w_wr_en = 1'b1;
                    n_held  = r_held + CNT_W'(1);
                end
            end
            ST_SCAN: begin
                // row turns once; the front cell is looked at each cycle
                w_shift    = 1'b1;
                w_rotate   = 1'b1;
                n_scan_idx = r_scan_idx + IDX_W'(1);
                if (!r_stopped && w_scan_stop) n_stopped = 1'b1;
                if (w_scan_take) begin
                    n_next_exp = w_front.ack + 16'd1;
                    if (w_grp_done) begin
                        n_consumed   = CNT_W'(r_scan_idx) + CNT_W'(1);
                        n_frags_seen = '0;
                    end else begin
                        n_frags_seen = w_frags_inc;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    w_shift     = 1'b1;
                    n_consumed  = r_consumed - CNT_W'(1);
                    n_held      = r_held - CNT_W'(1);
                    n_base      = r_base + 16'd1;
                    n_out_valid = 1'b1;
                    n_ev        = 1'b0;
                    n_o_handle  = w_front.handle;
                    n_o_opcode  = w_front.opcode;
                    n_o_length  = w_front.length;
                    n_o_end     = w_piece_end;
                    n_o_mlen    = !w_piece_end ? 20'd0 :
                                  (w_sum > 21'(MSG_LEN_MAX)) ? MSG_LEN_MAX : w_sum[19:0];
                    n_o_ack     = '0;
                    n_o_last    = (r_consumed == CNT_W'(1));
                    if (w_piece_end) begin
                        n_grp_cnt = '0;
                        n_grp_sum = '0;
                    end else begin
                        n_grp_cnt = w_grp_inc;
                        n_grp_sum = w_sum;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_next_exp   <= '0;
            r_base       <= '0;
            r_last_ack   <= '0;
            r_held       <= '0;
            r_scan_idx   <= '0;
            r_stopped    <= 1'b0;
            r_consumed   <= '0;
            r_frags_seen <= '0;
            r_grp_cnt    <= '0;
            r_grp_sum    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_next_exp   <= n_next_exp;
            r_base       <= n_base;
            r_last_ack   <= n_last_ack;
            r_held       <= n_held;
            r_scan_idx   <= n_scan_idx;
            r_stopped    <= n_stopped;
            r_consumed   <= n_consumed;
            r_frags_seen <= n_frags_seen;
            r_grp_cnt    <= n_grp_cnt;
            r_grp_sum    <= n_grp_sum;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev       <= n_ev;
        r_o_handle <= n_o_handle;
        r_o_opcode <= n_o_opcode;
        r_o_length <= n_o_length;
        r_o_end    <= n_o_end;
        r_o_mlen   <= n_o_mlen;
        r_o_ack    <= n_o_ack;
        r_o_last   <= n_o_last;
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_ev;
    assign o_piece_handle   = r_o_handle;
    assign o_piece_opcode   = r_o_opcode;
    assign o_piece_length   = r_o_length;
    assign o_message_end    = r_o_end;
    assign o_message_length = r_o_mlen;
    assign o_ack_value      = r_o_ack;
    assign o_last           = r_o_last;

    // ---------------- checks ----------------
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CNT_W'(WINDOW_DEPTH))
        else $error("held count beyond window depth");

    a_emit_occupied: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> w_occ[0])
        else $error("drain reached an empty slot");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EVAL || $past(r_state) == ST_EMIT))
        else $error("result raised outside evaluation or drain");

endmodule
`default_nettype wire

// ===== design/arwr_cell.sv =====
`default_nettype none
module arwr_cell
    import arwr_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_wr_en,
    input  t_slot i_wr_data,
    input  wire   i_shift,
    input  t_slot i_shift_data,
    output t_slot o_slot
);

    logic [15:0] r_ack;
    logic [15:0] r_frags;
    logic [15:0] r_opcode;
    logic [15:0] r_length;
    logic [15:0] r_handle;

    // ack is the occupancy mark, so only it is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack <= '0;
        end else if (i_wr_en) begin
            r_ack <= i_wr_data.ack;
        end else if (i_shift) begin
            r_ack <= i_shift_data.ack;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_frags  <= i_wr_data.frags;
            r_opcode <= i_wr_data.opcode;
            r_length <= i_wr_data.length;
            r_handle <= i_wr_data.handle;
        end else if (i_shift) begin
            r_frags  <= i_shift_data.frags;
            r_opcode <= i_shift_data.opcode;
            r_length <= i_shift_data.length;
            r_handle <= i_shift_data.handle;
        end
    end

    assign o_slot = '{ack: r_ack, frags: r_frags, opcode: r_opcode,
                      length: r_length, handle: r_handle};

endmodule
`default_nettype wire
